/* src/crp_pkg.sv */
`default_nettype none

package crp_pkg;

  // frame numbering is fixed by the 6-bit frame field
  localparam int FRAME_W  = 6;
  localparam int FRAMES   = 64;
  localparam int COUNT_W  = 7;
  localparam int CAPACITY = 64;

  // operation codes
  localparam logic [1:0] OP_VICTIM = 2'd0;
  localparam logic [1:0] OP_PIN    = 2'd1;
  localparam logic [1:0] OP_UNPIN  = 2'd2;

  // command item
  typedef struct packed {
    logic [1:0]         operation;
    logic [FRAME_W-1:0] frame;
  } cmd_t;

  // result item
  typedef struct packed {
    logic               found;
    logic [FRAME_W-1:0] victim_frame;
    logic [COUNT_W-1:0] ring_count;
    logic               overflow;
  } result_t;

  // one ring entry as held in the store
  typedef struct packed {
    logic               member;
    logic               refb;
    logic [FRAME_W-1:0] nxt;
    logic [FRAME_W-1:0] prv;
  } entry_t;

  // access request from the sequencer to the entry store
  typedef struct packed {
    logic               rd_en;
    logic [FRAME_W-1:0] rd_addr;
    logic               wr_en;
    logic [FRAME_W-1:0] wr_addr;
    entry_t             wr_data;
  } store_req_t;

endpackage

`default_nettype wire

/* src/clock_replacement_policy_unit.sv */
`default_nettype none

// CLOCK page replacer for a buffer pool of 64 frames.
// Command channel: an item (operation, frame) is taken at a rising edge with
// start high and busy low. Operations: victim request, pin frame, unpin frame.
// Result channel: done is high for exactly one cycle with the result item on
// result; the receiver cannot stall it, so it must take it in that cycle.
// Ring entries (membership, reference bit, next/prev links) live in one
// RAM with one read and one write port and a registered read; the sequencer
// reads, modifies and writes back one entry per cycle, forwarding a write
// into a read of the same entry.
// An unpin of a member, a refused unpin, a pin of a non-member, a victim
// request on an empty ring or an unpin into an empty ring end in EVAL; an
// unpin into a non-empty ring runs INS1-INS3, a pin of a member UL1-UL3; a
// victim request sweeps past set reference bits (at most the ring size, 64),
// then runs UL1-UL3. Each sweep step is one link read of the RAM.
// A new item can be accepted in the cycle done is high.
// Reset (synchronous, active high) empties the ring at once: valid bits in
// flip-flops clear, hand and count go to zero; no clearing pass is needed.
module clock_replacement_policy_unit #(
  parameter int CAPACITY = crp_pkg::CAPACITY
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire crp_pkg::cmd_t    command,
  output logic                  done,
  output crp_pkg::result_t      result
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_EVAL = 8'b0000_0010,
    ST_UL1  = 8'b0000_0100,
    ST_UL2  = 8'b0000_1000,
    ST_UL3  = 8'b0001_0000,
    ST_INS1 = 8'b0010_0000,
    ST_INS2 = 8'b0100_0000,
    ST_INS3 = 8'b1000_0000
  } state_t;

  localparam int FW = crp_pkg::FRAME_W;
  localparam int CW = crp_pkg::COUNT_W;

  state_t               state, state_next;
  logic [1:0]           op, op_next;
  logic [FW-1:0]        frm, frm_next;
  logic [FW-1:0]        cur, cur_next;
  logic [FW-1:0]        hand, hand_next;
  logic [CW-1:0]        count, count_next;
  logic [FW-1:0]        lp, lp_next;
  logic [FW-1:0]        ln, ln_next;
  logic [FW-1:0]        uf, uf_next;
  logic                 done_next;
  crp_pkg::result_t     res_next;

  crp_pkg::store_req_t  req;
  crp_pkg::entry_t      ent;

  logic                 found_n;
  logic [FW-1:0]        victim_n;
  logic                 ovf_n;
  logic                 ring_full;

  crp_store u_store (
    .clk(clk),
    .rst(rst),
    .req(req),
    .ent(ent)
  );

  assign busy      = (state != ST_IDLE);
  assign ring_full = (32'(count) >= CAPACITY);

  // sequencer
  always_comb begin
    state_next = state;
    op_next    = op;
    frm_next   = frm;
    cur_next   = cur;
    hand_next  = hand;
    count_next = count;
    lp_next    = lp;
    ln_next    = ln;
    uf_next    = uf;
    done_next  = 1'b0;
    res_next   = result;
    req        = '0;
    found_n    = 1'b0;
    victim_n   = '0;
    ovf_n      = 1'b0;

    case (state)
      ST_IDLE: begin
        if (start) begin
          op_next     = command.operation;
          frm_next    = command.frame;
          req.rd_en   = 1'b1;
          req.rd_addr = (command.operation == crp_pkg::OP_VICTIM) ? hand : command.frame;
          cur_next    = req.rd_addr;
          state_next  = ST_EVAL;
        end
      end

      ST_EVAL: begin
        case (op)
          crp_pkg::OP_VICTIM: begin
            if (count == '0) begin
              done_next = 1'b1;
            end else if (ent.refb) begin
              // second chance: clear the bit and move on
              req.wr_en        = 1'b1;
              req.wr_addr      = cur;
              req.wr_data      = ent;
              req.wr_data.refb = 1'b0;
              req.rd_en        = 1'b1;
              req.rd_addr      = ent.nxt;
              cur_next         = ent.nxt;
            end else begin
              hand_next   = ent.nxt;
              uf_next     = cur;
              lp_next     = ent.prv;
              ln_next     = ent.nxt;
              req.rd_en   = 1'b1;
              req.rd_addr = ent.prv;
              state_next  = ST_UL1;
            end
          end
          crp_pkg::OP_PIN: begin
            if (!ent.member) begin
              done_next = 1'b1;
            end else begin
              if (hand == frm) begin
                hand_next = ent.nxt;
              end
              uf_next     = frm;
              lp_next     = ent.prv;
              ln_next     = ent.nxt;
              req.rd_en   = 1'b1;
              req.rd_addr = ent.prv;
              state_next  = ST_UL1;
            end
          end
          crp_pkg::OP_UNPIN: begin
            if (ent.member) begin
              req.wr_en        = 1'b1;
              req.wr_addr      = frm;
              req.wr_data      = ent;
              req.wr_data.refb = 1'b1;
              done_next        = 1'b1;
            end else if (ring_full) begin
              ovf_n     = 1'b1;
              done_next = 1'b1;
            end else if (count == '0) begin
              // first entry links to itself
              req.wr_en   = 1'b1;
              req.wr_addr = frm;
              req.wr_data = '{member: 1'b1, refb: 1'b1, nxt: frm, prv: frm};
              hand_next   = frm;
              count_next  = count + CW'(1);
              done_next   = 1'b1;
            end else begin
              req.rd_en   = 1'b1;
              req.rd_addr = hand;
              state_next  = ST_INS1;
            end
          end
          default: begin
            done_next = 1'b1;
          end
        endcase
      end

      // unlink: prev.nxt <= next
      ST_UL1: begin
        req.wr_en       = 1'b1;
        req.wr_addr     = lp;
        req.wr_data     = ent;
        req.wr_data.nxt = ln;
        req.rd_en       = 1'b1;
        req.rd_addr     = ln;
        state_next      = ST_UL2;
      end

      // unlink: next.prv <= prev
      ST_UL2: begin
        req.wr_en       = 1'b1;
        req.wr_addr     = ln;
        req.wr_data     = ent;
        req.wr_data.prv = lp;
        req.rd_en       = 1'b1;
        req.rd_addr     = uf;
        state_next      = ST_UL3;
      end

      // unlink: drop membership and bit
      ST_UL3: begin
        req.wr_en          = 1'b1;
        req.wr_addr        = uf;
        req.wr_data        = ent;
        req.wr_data.member = 1'b0;
        req.wr_data.refb   = 1'b0;
        count_next         = count - CW'(1);
        found_n            = (op == crp_pkg::OP_VICTIM);
        victim_n           = found_n ? uf : '0;
        done_next          = 1'b1;
        state_next         = ST_IDLE;
      end

      // insert before hand: hand.prv <= frame, fetch old prev
      ST_INS1: begin
        lp_next         = ent.prv;
        req.wr_en       = 1'b1;
        req.wr_addr     = hand;
        req.wr_data     = ent;
        req.wr_data.prv = frm;
        req.rd_en       = 1'b1;
        req.rd_addr     = ent.prv;
        state_next      = ST_INS2;
      end

      // old prev.nxt <= frame
      ST_INS2: begin
        req.wr_en       = 1'b1;
        req.wr_addr     = lp;
        req.wr_data     = ent;
        req.wr_data.nxt = frm;
        state_next      = ST_INS3;
      end

      // new entry
      ST_INS3: begin
        req.wr_en   = 1'b1;
        req.wr_addr = frm;
        req.wr_data = '{member: 1'b1, refb: 1'b1, nxt: hand, prv: lp};
        count_next  = count + CW'(1);
        done_next   = 1'b1;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // result item goes out the cycle after the last step
    if (done_next) begin
      state_next = ST_IDLE;
      res_next   = '{found: found_n, victim_frame: victim_n,
                     ring_count: count_next, overflow: ovf_n};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      hand  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      hand  <= hand_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op     <= op_next;
    frm    <= frm_next;
    cur    <= cur_next;
    lp     <= lp_next;
    ln     <= ln_next;
    uf     <= uf_next;
    result <= res_next;
  end

  // checks
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not start the sequencer");

  a_write_busy: assert property (@(posedge clk) disable iff (rst)
    req.wr_en |-> busy)
    else $error("store write while idle");

  a_found_ovf: assert property (@(posedge clk) disable iff (rst)
    done |-> !(result.found && result.overflow))
    else $error("result flags both found and overflow");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= crp_pkg::FRAMES)
    else $error("ring count above frame count");

  a_evict_count: assert property (@(posedge clk) disable iff (rst)
    (done && result.found) |-> (32'(result.ring_count) + 1 == 32'($past(count))))
    else $error("eviction did not shrink the ring by one");

endmodule

`default_nettype wire

/* src/crp_ram.sv */
`default_nettype none

// simple dual-port RAM, registered read
module crp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/crp_store.sv */
`default_nettype none

// entry store: RAM, per-entry valid bits and write-to-read forwarding
module crp_store (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire crp_pkg::store_req_t req,
  output crp_pkg::entry_t          ent
);

  logic [crp_pkg::FRAMES-1:0] valid;
  logic                       vld_q;
  logic                       fwd_hit;
  crp_pkg::entry_t            fwd_data;
  logic [$bits(crp_pkg::entry_t)-1:0] rdata;

  crp_ram #(
    .WIDTH($bits(crp_pkg::entry_t)),
    .DEPTH(crp_pkg::FRAMES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (req.wr_en),
    .wr_addr(req.wr_addr),
    .wr_data(req.wr_data),
    .rd_en  (req.rd_en),
    .rd_addr(req.rd_addr),
    .rd_data(rdata)
  );

  // valid bits: an entry never written reads as all zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      fwd_hit <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      fwd_hit <= req.rd_en && req.wr_en && (req.rd_addr == req.wr_addr);
    end
  end

  // read side registers, captured with the RAM read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      vld_q    <= valid[req.rd_addr];
      fwd_data <= req.wr_data;
    end
  end

  // same-address write in the read cycle wins
  always_comb begin
    if (fwd_hit) begin
      ent = fwd_data;
    end else if (vld_q) begin
      ent = crp_pkg::entry_t'(rdata);
    end else begin
      ent = '0;
    end
  end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  // the fourth operation code is unused and must leave the ring alone
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEM_TARGET = 1250;
  // longest victim sweep plus margin
  localparam int SETTLE_CYCLES = 160;

  typedef struct {
    crp_pkg::cmd_t cmd;
    bit            drain;   // hold the item until every outstanding result is back
  } pending_cmd_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  crp_pkg::cmd_t    command = '0;
  logic             busy;
  logic             done;
  crp_pkg::result_t result;

  clock_replacement_policy_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .done(done),
    .result(result)
  );

  // predicted ring state
  bit       in_ring [crp_pkg::FRAMES];
  bit       ref_set [crp_pkg::FRAMES];
  bit [5:0] link_next [crp_pkg::FRAMES];
  bit [5:0] link_prev [crp_pkg::FRAMES];
  bit [5:0] hand_pos = '0;
  int       ring_size = 0;

  pending_cmd_t     pending_cmds[$];
  crp_pkg::result_t expected_results[$];

  int  fail_count = 0;
  int  cycle_count = 0;
  int  items_taken = 0;
  int  results_seen = 0;
  int  evictions = 0;
  int  full_ring_results = 0;
  int  gap_left = 0;
  int  burst_left = 0;
  bit  item_taken = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  // take a frame out of the predicted ring
  function automatic void unlink_frame(bit [5:0] f);
    link_next[link_prev[f]] = link_next[f];
    link_prev[link_next[f]] = link_prev[f];
    in_ring[f] = 1'b0;
    ref_set[f] = 1'b0;
    if (ring_size > 0) ring_size--;
  endfunction

  // apply one command to the predicted ring and return the expected result
  function automatic crp_pkg::result_t ring_step(crp_pkg::cmd_t c);
    crp_pkg::result_t r;
    bit [5:0] f;
    bit [5:0] h;
    bit [5:0] p;
    int       g;
    r = '0;
    f = c.frame;
    case (c.operation)
      crp_pkg::OP_VICTIM: begin
        if (ring_size > 0) begin
          h = hand_pos;
          // one full turn clears every bit, so the sweep is bounded
          for (g = 0; g <= 2 * crp_pkg::FRAMES + 1 && ref_set[h]; g++) begin
            ref_set[h] = 1'b0;
            h = link_next[h];
          end
          r.found = 1'b1;
          r.victim_frame = h;
          hand_pos = link_next[h];
          unlink_frame(h);
        end
      end
      crp_pkg::OP_PIN: begin
        if (in_ring[f]) begin
          if (hand_pos == f) hand_pos = link_next[f];
          unlink_frame(f);
        end
      end
      crp_pkg::OP_UNPIN: begin
        if (in_ring[f]) begin
          ref_set[f] = 1'b1;
        end else if (ring_size >= crp_pkg::CAPACITY) begin
          r.overflow = 1'b1;
        end else begin
          if (ring_size == 0) begin
            link_next[f] = f;
            link_prev[f] = f;
            hand_pos = f;
          end else begin
            // insert just behind the hand
            h = hand_pos;
            p = link_prev[h];
            link_next[p] = f;
            link_prev[f] = p;
            link_next[f] = h;
            link_prev[h] = f;
          end
          in_ring[f] = 1'b1;
          ref_set[f] = 1'b1;
          ring_size++;
        end
      end
      default: ;
    endcase
    r.ring_count = ring_size[crp_pkg::COUNT_W-1:0];
    return r;
  endfunction

  // mostly short gaps, a few long ones, and bursts with none
  function automatic int pick_gap();
    int roll;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 4) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  task automatic queue_cmd(logic [1:0] op, int frame_no, bit drain = 1'b0);
    pending_cmd_t item;
    item.cmd.operation = op;
    item.cmd.frame = frame_no[crp_pkg::FRAME_W-1:0];
    item.drain = drain;
    pending_cmds.push_back(item);
  endtask

  // driver: present items at the falling edge, hold each until taken
  always @(negedge clk) begin : drive
    if (rst) begin
      start <= 1'b0;
    end else if (start && !item_taken) begin
      // still waiting for the block to take the current item
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left = gap_left - 1;
    end else if (pending_cmds.size() > 0 &&
                 !(pending_cmds[0].drain && (expected_results.size() > 0 || start))) begin
      command <= pending_cmds[0].cmd;
      start <= 1'b1;
      void'(pending_cmds.pop_front());
      gap_left = pick_gap();
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: check results, then predict for any item taken at this edge
  always @(posedge clk) begin : observe
    crp_pkg::result_t want;
    cycle_count++;
    if (rst) begin
      item_taken = 1'b0;
    end else begin
      if (done) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result with no item outstanding: %p", result);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (result.found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, result.found);
            fail_count++;
          end
          if (result.victim_frame !== want.victim_frame) begin
            $error("victim_frame: expected %0d, got %0d", want.victim_frame,
                   result.victim_frame);
            fail_count++;
          end
          if (result.ring_count !== want.ring_count) begin
            $error("ring_count: expected %0d, got %0d", want.ring_count, result.ring_count);
            fail_count++;
          end
          if (result.overflow !== want.overflow) begin
            $error("overflow: expected %0d, got %0d", want.overflow, result.overflow);
            fail_count++;
          end
          if (want.found) evictions++;
          if (want.ring_count == crp_pkg::CAPACITY) full_ring_results++;
        end
      end
      item_taken = start && !busy;
      if (item_taken) begin
        expected_results.push_back(ring_step(command));
        items_taken++;
      end
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin : stimulus
    int       kind;
    int       n;
    int       base;
    int       roll;
    int       j;
    int       k;
    int       t;
    int       order[crp_pkg::FRAMES];
    bit [1:0] op;

    for (j = 0; j < crp_pkg::FRAMES; j++) begin
      in_ring[j] = 1'b0;
      ref_set[j] = 1'b0;
      link_next[j] = '0;
      link_prev[j] = '0;
    end

    // directed: empty ring, unused code, membership, pin of the hand frame
    queue_cmd(crp_pkg::OP_VICTIM, 63);
    queue_cmd(OP_UNUSED, 0);
    queue_cmd(crp_pkg::OP_PIN, 42);
    queue_cmd(crp_pkg::OP_UNPIN, 0);
    queue_cmd(crp_pkg::OP_UNPIN, 63);
    queue_cmd(crp_pkg::OP_UNPIN, 0);
    queue_cmd(crp_pkg::OP_UNPIN, 21);
    queue_cmd(OP_UNUSED, 63);
    queue_cmd(crp_pkg::OP_VICTIM, 0);
    queue_cmd(crp_pkg::OP_PIN, 21);
    queue_cmd(crp_pkg::OP_PIN, 63);
    queue_cmd(crp_pkg::OP_VICTIM, 5);
    queue_cmd(crp_pkg::OP_VICTIM, 0);
    queue_cmd(crp_pkg::OP_UNPIN, 42);
    queue_cmd(crp_pkg::OP_PIN, 42);
    queue_cmd(crp_pkg::OP_UNPIN, 7);
    queue_cmd(crp_pkg::OP_UNPIN, 9);
    queue_cmd(crp_pkg::OP_PIN, 7);
    queue_cmd(crp_pkg::OP_UNPIN, 7);
    queue_cmd(crp_pkg::OP_VICTIM, 42);
    queue_cmd(crp_pkg::OP_PIN, 9);
    queue_cmd(crp_pkg::OP_VICTIM, 0);
    queue_cmd(crp_pkg::OP_UNPIN, 33, 1'b1);

    // random sequences
    while (pending_cmds.size() < ITEM_TARGET) begin
      kind = $urandom_range(0, 99);
      if (kind < 3) begin
        // wait for the block to drain before carrying on
        queue_cmd(crp_pkg::OP_VICTIM, $urandom_range(0, 63), 1'b1);
      end else if (kind < 12) begin
        // fill the ring completely in random order, touch it, then evict some
        for (j = 0; j < crp_pkg::FRAMES; j++) order[j] = j;
        for (j = crp_pkg::FRAMES - 1; j > 0; j--) begin
          k = $urandom_range(0, j);
          t = order[j];
          order[j] = order[k];
          order[k] = t;
        end
        for (j = 0; j < crp_pkg::FRAMES; j++) queue_cmd(crp_pkg::OP_UNPIN, order[j]);
        n = $urandom_range(0, 8);
        for (j = 0; j < n; j++) queue_cmd(crp_pkg::OP_UNPIN, $urandom_range(0, 63));
        n = $urandom_range(1, 10);
        for (j = 0; j < n; j++) queue_cmd(crp_pkg::OP_VICTIM, $urandom_range(0, 63));
      end else if (kind < 25) begin
        // drain: a run of victims with the odd unpin mixed in
        n = $urandom_range(5, 70);
        for (j = 0; j < n; j++) begin
          if ($urandom_range(0, 9) == 0) queue_cmd(crp_pkg::OP_UNPIN, $urandom_range(0, 63));
          else queue_cmd(crp_pkg::OP_VICTIM, $urandom_range(0, 63));
        end
      end else if (kind < 85) begin
        // busy traffic on a small set of frames so that hits are common
        base = $urandom_range(0, 63);
        n = $urandom_range(8, 40);
        for (j = 0; j < n; j++) begin
          roll = $urandom_range(0, 99);
          if (roll < 45) op = crp_pkg::OP_UNPIN;
          else if (roll < 65) op = crp_pkg::OP_PIN;
          else if (roll < 95) op = crp_pkg::OP_VICTIM;
          else op = OP_UNUSED;
          queue_cmd(op, (base + $urandom_range(0, 7)) & 63);
        end
      end else begin
        // noise
        n = $urandom_range(4, 20);
        for (j = 0; j < n; j++) queue_cmd(2'($urandom_range(0, 3)), $urandom_range(0, 63));
      end
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // wait for the queue to empty and the last results to come back
    while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d items and checked %0d results in %0d cycles.", items_taken,
             results_seen, cycle_count);
    $display("Evictions: %0d; results with a full ring: %0d.", evictions,
             full_ring_results);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
